[hdl/aae_pkg.sv]
// ----------------------------------------------------------------------------
// aae_pkg
// shared constants, datapath command codes, status bundle and helper function
// ----------------------------------------------------------------------------
package aae_pkg;

    localparam int SYMBOLS_DEF     = 256;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int RANGE_BITS_DEF  = 60;
    localparam int SYM_W           = 8;
    localparam int OUT_BITS_W      = 61;
    localparam int OUT_CNT_W       = 6;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLEAR,
        DP_ACCEPT,
        DP_POS,
        DP_CJ,
        DP_WALK_RD,
        DP_WALK_ACC,
        DP_SET_END,
        DP_MUL_INIT,
        DP_MUL_STEP,
        DP_DIV_STEP,
        DP_STORE,
        DP_NARROW,
        DP_RENORM,
        DP_FLUSH_EMIT,
        DP_SET_OVF,
        DP_INC,
        DP_SCAN_RD,
        DP_SCAN_CMP,
        DP_SWAP_RD,
        DP_SWAP_W1,
        DP_SWAP_W2,
        DP_UP_RD,
        DP_UP_WR,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        logic is_flush;
        logic sym_oob;
        logic cur_zero;
        logic k_zero;
        logic scan_eq;
        logic mul_last;
        logic div_last;
        logic phase;
        logic renorm_stop;
        logic clr_last;
        logic sat;
    } t_dp_status;

    // number of slots in the left subtree of slot p in a heap of n slots
    function automatic int f_left_size(input int p, input int n);
        int c;
        int first;
        int last;
        int size;
        c    = 2 * p + 1;
        size = 0;
        for (int d = 0; d < 9; d++) begin
            first = ((c + 1) << d) - 1;
            last  = first + (1 << d) - 1;
            if (last > n - 1) begin
                last = n - 1;
            end
            if (first < n) begin
                size = size + last - first + 1;
            end
        end
        return size;
    endfunction

endpackage

[hdl/aae_ctrl.sv]
// ----------------------------------------------------------------------------
// aae_ctrl
// sequencer: issues datapath commands per item and owns the handshakes
// ----------------------------------------------------------------------------
module aae_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_stall,
    input  aae_pkg::t_dp_status i_status,
    output aae_pkg::t_dp_op     o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_CJ,
        ST_WALK,
        ST_WALK_ACC,
        ST_MUL_INIT,
        ST_MUL,
        ST_DIV,
        ST_STORE,
        ST_NARROW,
        ST_RENORM,
        ST_FLUSH_EMIT,
        ST_SAT,
        ST_SCAN,
        ST_SCAN_CMP,
        ST_SWAP_RD,
        ST_SWAP_W1,
        ST_SWAP_W2,
        ST_UP,
        ST_UP_WR,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = aae_pkg::DP_NOP;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd = aae_pkg::DP_CLEAR;
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = aae_pkg::DP_ACCEPT;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_status.is_flush) begin
                    n_state = ST_MUL_INIT;
                end else if (i_status.sym_oob) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd   = aae_pkg::DP_POS;
                    n_state = ST_CJ;
                end
            end
            ST_CJ: begin
                o_cmd   = aae_pkg::DP_CJ;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (i_status.cur_zero) begin
                    o_cmd   = aae_pkg::DP_SET_END;
                    n_state = ST_MUL_INIT;
                end else begin
                    o_cmd   = aae_pkg::DP_WALK_RD;
                    n_state = ST_WALK_ACC;
                end
            end
            ST_WALK_ACC: begin
                o_cmd   = aae_pkg::DP_WALK_ACC;
                n_state = ST_WALK;
            end
            ST_MUL_INIT: begin
                o_cmd   = aae_pkg::DP_MUL_INIT;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd = aae_pkg::DP_MUL_STEP;
                if (i_status.mul_last) n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd = aae_pkg::DP_DIV_STEP;
                if (i_status.div_last) n_state = ST_STORE;
            end
            ST_STORE: begin
                o_cmd   = aae_pkg::DP_STORE;
                n_state = i_status.phase ? ST_NARROW : ST_MUL_INIT;
            end
            ST_NARROW: begin
                o_cmd   = aae_pkg::DP_NARROW;
                n_state = ST_RENORM;
            end
            ST_RENORM: begin
                if (i_status.renorm_stop) begin
                    n_state = i_status.is_flush ? ST_FLUSH_EMIT : ST_SAT;
                end else begin
                    o_cmd = aae_pkg::DP_RENORM;
                end
            end
            ST_FLUSH_EMIT: begin
                o_cmd   = aae_pkg::DP_FLUSH_EMIT;
                n_state = ST_DONE;
            end
            ST_SAT: begin
                if (i_status.sat) begin
                    o_cmd   = aae_pkg::DP_SET_OVF;
                    n_state = ST_DONE;
                end else begin
                    o_cmd   = aae_pkg::DP_INC;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.k_zero) begin
                    n_state = ST_SWAP_RD;
                end else begin
                    o_cmd   = aae_pkg::DP_SCAN_RD;
                    n_state = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                o_cmd   = aae_pkg::DP_SCAN_CMP;
                n_state = i_status.scan_eq ? ST_SCAN : ST_SWAP_RD;
            end
            ST_SWAP_RD: begin
                o_cmd   = aae_pkg::DP_SWAP_RD;
                n_state = ST_SWAP_W1;
            end
            ST_SWAP_W1: begin
                o_cmd   = aae_pkg::DP_SWAP_W1;
                n_state = ST_SWAP_W2;
            end
            ST_SWAP_W2: begin
                o_cmd   = aae_pkg::DP_SWAP_W2;
                n_state = ST_UP;
            end
            ST_UP: begin
                if (i_status.cur_zero) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd   = aae_pkg::DP_UP_RD;
                    n_state = ST_UP_WR;
                end
            end
            ST_UP_WR: begin
                o_cmd   = aae_pkg::DP_UP_WR;
                n_state = ST_UP;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd       = aae_pkg::DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = i_status.is_flush ? ST_CLEAR : ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[hdl/aae_dp.sv]
// ----------------------------------------------------------------------------
// aae_dp
// model memories, interval registers, serial multiply and divide, bit packer
// ----------------------------------------------------------------------------
module aae_dp #(
    parameter int SYMBOLS     = aae_pkg::SYMBOLS_DEF,
    parameter int COUNT_WIDTH = aae_pkg::COUNT_WIDTH_DEF,
    parameter int RANGE_BITS  = aae_pkg::RANGE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  aae_pkg::t_dp_op                     i_cmd,
    input  logic                                i_op,
    input  logic [aae_pkg::SYM_W-1:0]           i_symbol,
    output aae_pkg::t_dp_status                 o_status,
    output logic [aae_pkg::OUT_BITS_W-1:0]      o_out_bits,
    output logic [aae_pkg::OUT_CNT_W-1:0]       o_out_count,
    output logic                                o_count_overflow
);

    localparam int IW   = (SYMBOLS > 2) ? $clog2(SYMBOLS) : 1;
    localparam int CW   = COUNT_WIDTH;
    localparam int RB   = RANGE_BITS;
    localparam int WW   = RB + 1;
    localparam int PW   = WW + CW;
    localparam int CNTW = $clog2(PW + 1);
    localparam int OW   = aae_pkg::OUT_BITS_W;
    localparam int NW   = aae_pkg::OUT_CNT_W;
    localparam int SW   = aae_pkg::SYM_W;

    logic [CW-1:0] mem_cnt  [SYMBOLS];
    logic [CW-1:0] mem_lsum [SYMBOLS];
    logic [IW-1:0] mem_sos  [SYMBOLS];
    logic [IW-1:0] mem_sop  [SYMBOLS];

    logic [CW-1:0] r_cnt_rd, r_lsum_rd;
    logic [IW-1:0] r_sos_rd, r_sop_rd;

    logic          cnt_we, lsum_we, sos_we, sop_we;
    logic          cnt_re, lsum_re, sos_re, sop_re;
    logic [IW-1:0] cnt_wa, lsum_wa, sos_wa, sop_wa;
    logic [IW-1:0] cnt_ra, lsum_ra, sos_ra, sop_ra;
    logic [CW-1:0] cnt_wd, lsum_wd;
    logic [IW-1:0] sos_wd, sop_wd;

    logic            r_op;
    logic [SW-1:0]   r_sym;
    logic [IW-1:0]   r_idx, r_j, r_k, r_cur;
    logic [CW-1:0]   r_cj, r_begin, r_b, r_e, r_mult, r_rem, r_total;
    logic [RB-1:0]   r_low, r_high;
    logic [PW-1:0]   r_prod;
    logic [WW-1:0]   r_qb, r_qe;
    logic [CNTW-1:0] r_cnt;
    logic            r_phase, r_ovf;
    logic [OW-1:0]   r_acc;
    logic [NW-1:0]   r_n;

    logic [WW-1:0]   w;
    logic [IW-1:0]   parent, sym_idx;
    logic [CW:0]     t_rem;
    logic            div_ge;

    assign sym_idx = r_sym[IW-1:0];
    assign parent  = (r_cur - IW'(1)) >> 1;
    assign w       = (r_high >= r_low) ? ({1'b0, r_high} - {1'b0, r_low} + WW'(1)) : '0;
    assign t_rem   = {r_rem, r_prod[PW-1]};
    assign div_ge  = (t_rem >= {1'b0, r_total});

    always_comb begin
        o_status.is_flush    = r_op;
        o_status.sym_oob     = ({1'b0, r_sym} >= (SW + 1)'(SYMBOLS));
        o_status.cur_zero    = (r_cur == '0);
        o_status.k_zero      = (r_k == '0);
        o_status.scan_eq     = (r_cnt_rd == r_cj);
        o_status.mul_last    = (r_cnt == CNTW'(CW - 1));
        o_status.div_last    = (r_cnt == CNTW'(PW - 1));
        o_status.phase       = r_phase;
        o_status.renorm_stop = (r_low[RB-1] ^ r_high[RB-1]) || (r_cnt == CNTW'(RB));
        o_status.clr_last    = (r_idx == IW'(SYMBOLS - 1));
        o_status.sat         = &r_total;
    end

    // memory port control
    always_comb begin
        cnt_we = 1'b0;  cnt_wa = r_idx;  cnt_wd = CW'(1);
        lsum_we = 1'b0; lsum_wa = r_idx; lsum_wd = CW'(aae_pkg::f_left_size(int'(r_idx), SYMBOLS));
        sos_we = 1'b0;  sos_wa = r_idx;  sos_wd = r_idx;
        sop_we = 1'b0;  sop_wa = r_idx;  sop_wd = r_idx;
        cnt_re = 1'b0;  cnt_ra = parent;
        lsum_re = 1'b0; lsum_ra = parent;
        sos_re = 1'b0;  sos_ra = r_k;
        sop_re = 1'b0;  sop_ra = i_symbol[IW-1:0];
        case (i_cmd)
            aae_pkg::DP_CLEAR: begin
                cnt_we = 1'b1; lsum_we = 1'b1; sos_we = 1'b1; sop_we = 1'b1;
            end
            aae_pkg::DP_ACCEPT:  sop_re = 1'b1;
            aae_pkg::DP_POS: begin
                cnt_re = 1'b1;
                cnt_ra = r_sop_rd;
            end
            aae_pkg::DP_WALK_RD: begin
                cnt_re  = 1'b1;
                lsum_re = 1'b1;
            end
            aae_pkg::DP_SCAN_RD: begin
                cnt_re = 1'b1;
                cnt_ra = r_k - IW'(1);
            end
            aae_pkg::DP_SWAP_RD: sos_re = 1'b1;
            aae_pkg::DP_SWAP_W1: begin
                sos_we = 1'b1; sos_wa = r_k;     sos_wd = sym_idx;
                sop_we = 1'b1; sop_wa = sym_idx; sop_wd = r_k;
                cnt_we = 1'b1; cnt_wa = r_k;     cnt_wd = r_cj + CW'(1);
            end
            aae_pkg::DP_SWAP_W2: begin
                sos_we = 1'b1; sos_wa = r_j;      sos_wd = r_sos_rd;
                sop_we = 1'b1; sop_wa = r_sos_rd; sop_wd = r_j;
            end
            aae_pkg::DP_UP_RD:   lsum_re = 1'b1;
            aae_pkg::DP_UP_WR: begin
                lsum_we = 1'b1;
                lsum_wa = parent;
                lsum_wd = r_lsum_rd + CW'(r_cur[0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we)  mem_cnt[cnt_wa]   <= cnt_wd;
        if (cnt_re)  r_cnt_rd          <= mem_cnt[cnt_ra];
        if (lsum_we) mem_lsum[lsum_wa] <= lsum_wd;
        if (lsum_re) r_lsum_rd         <= mem_lsum[lsum_ra];
        if (sos_we)  mem_sos[sos_wa]   <= sos_wd;
        if (sos_re)  r_sos_rd          <= mem_sos[sos_ra];
        if (sop_we)  mem_sop[sop_wa]   <= sop_wd;
        if (sop_re)  r_sop_rd          <= mem_sop[sop_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            case (i_cmd)
                aae_pkg::DP_CLEAR: begin
                    r_idx   <= r_idx + IW'(1);
                    r_total <= CW'(SYMBOLS + 1);
                    r_low   <= '0;
                    r_high  <= '1;
                end
                aae_pkg::DP_ACCEPT: begin
                    r_op    <= i_op;
                    r_sym   <= i_symbol;
                    r_acc   <= '0;
                    r_n     <= '0;
                    r_ovf   <= 1'b0;
                    r_phase <= 1'b0;
                    r_b     <= r_total - CW'(1);
                    r_e     <= r_total;
                end
                aae_pkg::DP_POS: begin
                    r_j   <= r_sop_rd;
                    r_cur <= r_sop_rd;
                end
                aae_pkg::DP_CJ: begin
                    r_cj    <= r_cnt_rd;
                    r_begin <= '0;
                end
                aae_pkg::DP_WALK_ACC: begin
                    r_begin <= r_begin + r_cnt_rd + (r_cur[0] ? '0 : r_lsum_rd);
                    r_cur   <= parent;
                end
                aae_pkg::DP_SET_END: begin
                    r_b <= r_begin;
                    r_e <= r_begin + r_cj;
                end
                aae_pkg::DP_MUL_INIT: begin
                    r_prod <= '0;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_mult <= r_phase ? r_e : r_b;
                end
                aae_pkg::DP_MUL_STEP: begin
                    r_prod <= (r_prod << 1) + (r_mult[CW-1] ? PW'(w) : '0);
                    r_mult <= r_mult << 1;
                    r_cnt  <= o_status.mul_last ? '0 : r_cnt + CNTW'(1);
                end
                aae_pkg::DP_DIV_STEP: begin
                    r_rem  <= div_ge ? CW'(t_rem - {1'b0, r_total}) : t_rem[CW-1:0];
                    r_prod <= {r_prod[PW-2:0], div_ge};
                    r_cnt  <= r_cnt + CNTW'(1);
                end
                aae_pkg::DP_STORE: begin
                    if (r_phase) r_qe <= r_prod[WW-1:0];
                    else         r_qb <= r_prod[WW-1:0];
                    r_phase <= 1'b1;
                end
                aae_pkg::DP_NARROW: begin
                    r_low  <= r_low + r_qb[RB-1:0];
                    r_high <= r_low + r_qe[RB-1:0] - RB'(1);
                    r_cnt  <= '0;
                end
                aae_pkg::DP_RENORM: begin
                    r_acc  <= {r_acc[OW-2:0], r_low[RB-1]};
                    r_n    <= r_n + NW'(1);
                    r_low  <= {r_low[RB-2:0], 1'b0};
                    r_high <= {r_high[RB-2:0], 1'b1};
                    r_cnt  <= r_cnt + CNTW'(1);
                end
                aae_pkg::DP_FLUSH_EMIT: begin
                    r_acc <= {r_acc[OW-2:0], r_high[RB-1]};
                    r_n   <= r_n + NW'(1);
                    r_idx <= '0;
                end
                aae_pkg::DP_SET_OVF: r_ovf <= 1'b1;
                aae_pkg::DP_INC: begin
                    r_total <= r_total + CW'(1);
                    r_k     <= r_j;
                end
                aae_pkg::DP_SCAN_CMP: begin
                    if (o_status.scan_eq) r_k <= r_k - IW'(1);
                end
                aae_pkg::DP_SWAP_W2: r_cur <= r_k;
                aae_pkg::DP_UP_WR:   r_cur <= parent;
                aae_pkg::DP_OUT: begin
                    o_out_bits       <= r_acc;
                    o_out_count      <= r_n;
                    o_count_overflow <= r_ovf;
                end
                default: ;
            endcase
        end
    end

endmodule

[hdl/adaptive_arithmetic_encoder_top.sv]
// ----------------------------------------------------------------------------
// adaptive_arithmetic_encoder_top
// adaptive byte-wise arithmetic encoder with a sorted heap frequency model
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall carry op and symbol; op 0 codes the
// symbol, op 1 codes end of stream, emits a final bit and restarts the model.
// output channel: o_out_valid / i_out_stall carry one result per input
// transfer: up to 61 code bits right aligned, their count and the overflow
// flag. one item is worked on at a time; a new input transfer is taken while
// an earlier result still waits on the output register.
// per symbol: a tree walk up and a left sum update, a serial multiply and
// long division once per interval bound, the emitted bits and an
// equal-count scan; the shift-add multiplier and the one-bit-a-cycle
// divider set the floor of the time an item takes.
// a flush also runs the multiply and division and emits its bits, then a
// clearing pass over all SYMBOLS slots of the model memories runs before
// the next input transfer is taken; reset starts the same clearing pass.
// when the receiver stalls, the result holds and the block finishes at most
// one further item, then waits.
// ----------------------------------------------------------------------------
module adaptive_arithmetic_encoder_top #(
    parameter int SYMBOLS     = aae_pkg::SYMBOLS_DEF,
    parameter int COUNT_WIDTH = aae_pkg::COUNT_WIDTH_DEF,
    parameter int RANGE_BITS  = aae_pkg::RANGE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_op,
    input  logic [aae_pkg::SYM_W-1:0]          i_symbol,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [aae_pkg::OUT_BITS_W-1:0]     o_out_bits,
    output logic [aae_pkg::OUT_CNT_W-1:0]      o_out_count,
    output logic                               o_count_overflow
);

    aae_pkg::t_dp_op     cmd;
    aae_pkg::t_dp_status status;

    aae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    aae_dp #(
        .SYMBOLS     (SYMBOLS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .RANGE_BITS  (RANGE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_op             (i_op),
        .i_symbol         (i_symbol),
        .o_status         (status),
        .o_out_bits       (o_out_bits),
        .o_out_count      (o_out_count),
        .o_count_overflow (o_count_overflow)
    );

endmodule

[bench/adaptive_arithmetic_encoder_top_tb.sv]
// ----------------------------------------------------------------------------
// adaptive_arithmetic_encoder_top_tb
// self-checking bench: a behavioral copy of the adaptive model and 60-bit
// interval predicts the code bits of every input transfer; results are
// compared in order, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module adaptive_arithmetic_encoder_top_tb;

    localparam int NSYM = aae_pkg::SYMBOLS_DEF;
    localparam logic [63:0] RMASK = (64'd1 << aae_pkg::RANGE_BITS_DEF) - 1;
    localparam logic [63:0] RTOP  = 64'd1 << (aae_pkg::RANGE_BITS_DEF - 1);
    localparam logic [63:0] CMAX  = (64'd1 << aae_pkg::COUNT_WIDTH_DEF) - 1;
    localparam logic OP_SYMBOL = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;
    localparam int EXP_DEPTH = 64;

    typedef struct {
        logic [aae_pkg::OUT_BITS_W-1:0] bits;
        logic [aae_pkg::OUT_CNT_W-1:0]  count;
        logic                           ovf;
    } t_code_word;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic                           i_op = 1'b0;
    logic [aae_pkg::SYM_W-1:0]      i_symbol = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [aae_pkg::OUT_BITS_W-1:0] o_out_bits;
    logic [aae_pkg::OUT_CNT_W-1:0]  o_out_count;
    logic                           o_count_overflow;

    logic [63:0] m_count [NSYM];
    logic [63:0] m_left  [NSYM];
    logic [7:0]  m_sym   [NSYM];
    logic [63:0] m_total;
    logic [63:0] iv_low;
    logic [63:0] iv_high;
    logic [aae_pkg::OUT_BITS_W-1:0] acc_bits;
    logic [aae_pkg::OUT_CNT_W-1:0]  acc_n;

    t_code_word exp_fifo [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;
    int errors = 0;
    int hold_cycles = 0;
    bit no_idle = 0;

    adaptive_arithmetic_encoder_top uut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #100_000_000;
        $display("adaptive_arithmetic_encoder_top regression: fail");
        $finish;
    end

    function automatic void model_reset();
        int q;
        int odd;
        for (int p = 0; p < NSYM; p++) begin
            m_count[p] = 1;
            m_left[p]  = 0;
            m_sym[p]   = p[7:0];
        end
        for (int p = 1; p < NSYM; p++) begin
            q = p;
            while (q != 0) begin
                odd = q & 1;
                q = (q - 1) >> 1;
                m_left[q] = m_left[q] + odd;
            end
        end
        m_total = NSYM + 1;
        iv_low  = 0;
        iv_high = RMASK;
    endfunction

    function automatic logic [63:0] scale(logic [63:0] w, logic [63:0] c, logic [63:0] t);
        logic [127:0] prod;
        logic [127:0] quo;
        if (t == 0) return 0;
        prod = {64'd0, w} * {64'd0, c};
        quo  = prod / {64'd0, t};
        return quo[63:0];
    endfunction

    function automatic void put_bit(logic b);
        acc_bits = {acc_bits[aae_pkg::OUT_BITS_W-2:0], b};
        acc_n = acc_n + 1;
    endfunction

    function automatic void narrow(logic [63:0] b, logic [63:0] e);
        logic [63:0] w;
        logic [63:0] nl;
        logic [63:0] nh;
        w = (iv_high >= iv_low) ? iv_high - iv_low + 1 : 64'd0;
        nl = (iv_low + scale(w, b, m_total)) & RMASK;
        nh = (iv_low + scale(w, e, m_total) - 1) & RMASK;
        iv_low = nl;
        iv_high = nh;
        for (int g = 0; g < aae_pkg::RANGE_BITS_DEF; g++) begin
            if (((iv_low ^ iv_high) & RTOP) != 0) break;
            put_bit((iv_low & RTOP) != 0);
            iv_low  = (iv_low & (RTOP - 1)) << 1;
            iv_high = ((iv_high & (RTOP - 1)) << 1) | 64'd1;
        end
    endfunction

    function automatic void bump_slot(int j);
        int k;
        logic [7:0] s;
        if (j > 0 && m_count[j-1] == m_count[j]) begin
            k = j;
            while (k > 0 && m_count[k-1] == m_count[j]) k--;
            s = m_sym[k];
            m_sym[k] = m_sym[j];
            m_sym[j] = s;
            j = k;
        end
        m_count[j] = (m_count[j] + 1) & CMAX;
        while (j != 0) begin
            k = j & 1;
            j = (j - 1) >> 1;
            m_left[j] = (m_left[j] + k) & CMAX;
        end
    endfunction

    function automatic t_code_word encode_item(logic op, logic [7:0] sym);
        t_code_word r;
        int j;
        int pos;
        bit left;
        logic [63:0] begin_c;
        acc_bits = '0;
        acc_n = '0;
        r.ovf = 1'b0;
        if (op == OP_FLUSH) begin
            narrow(m_total - 1, m_total);
            put_bit((iv_high & RTOP) != 0);
            model_reset();
        end else if (sym < NSYM) begin
            j = 0;
            while (j < NSYM - 1 && m_sym[j] != sym) j++;
            pos = j;
            begin_c = 0;
            while (pos != 0) begin
                left = (pos & 1) != 0;
                pos = (pos - 1) >> 1;
                begin_c = begin_c + m_count[pos];
                if (!left) begin_c = begin_c + m_left[pos];
            end
            narrow(begin_c, begin_c + m_count[j]);
            if (m_total >= CMAX) begin
                r.ovf = 1'b1;
            end else begin
                m_total = m_total + 1;
                bump_slot(j);
            end
        end
        r.bits = acc_bits;
        r.count = acc_n;
        return r;
    endfunction

    task automatic send_item(logic op, logic [7:0] sym);
        int gap;
        bit took;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_symbol <= sym;
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end while (!took);
        exp_fifo[exp_wr % EXP_DEPTH] = encode_item(op, sym);
        exp_wr++;
    endtask

    // receiver: random stall before each transfer, long hold on request
    initial begin
        int n;
        bit took;
        forever begin
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 12);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                took = o_out_valid;
                @(posedge i_clk);
            end while (!took);
        end
    end

    always @(negedge i_clk) begin
        t_code_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_wr == exp_rd) begin
                $error("unexpected transfer bits=%h count=%0d", o_out_bits, o_out_count);
                errors++;
            end else begin
                exp_w = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_out_bits !== exp_w.bits) begin
                    $error("out_bits exp %h got %h", exp_w.bits, o_out_bits);
                    errors++;
                end
                if (o_out_count !== exp_w.count) begin
                    $error("out_count exp %0d got %0d", exp_w.count, o_out_count);
                    errors++;
                end
                if (o_count_overflow !== exp_w.ovf) begin
                    $error("count_overflow exp %0d got %0d", exp_w.ovf, o_count_overflow);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(OP_FLUSH, 8'h00);
        send_item(OP_FLUSH, 8'hFF);
        send_item(OP_SYMBOL, 8'h00);
        send_item(OP_SYMBOL, 8'hFF);
        send_item(OP_SYMBOL, 8'h55);
        send_item(OP_SYMBOL, 8'hAA);
        for (int i = 0; i < 6; i++) send_item(OP_SYMBOL, 8'hFF);
        for (int i = 0; i < 4; i++) send_item(OP_SYMBOL, 8'h80);
        send_item(OP_SYMBOL, 8'h01);
        send_item(OP_SYMBOL, 8'h7F);
        send_item(OP_FLUSH, 8'h00);
        for (int i = 0; i < 5; i++) send_item(OP_SYMBOL, 8'h00);
        send_item(OP_FLUSH, 8'hFF);
    endtask

    task automatic test_random(int n_items);
        int mode;
        int base;
        logic [7:0] sym;
        mode = 0;
        base = 0;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 49) == 0) begin
                send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
                mode = $urandom_range(0, 2);
                base = $urandom_range(0, 252);
            end else begin
                case (mode)
                    0: sym = 8'($urandom_range(0, 255));
                    1: sym = 8'(base + $urandom_range(0, 3));
                    default: sym = ($urandom_range(0, 3) != 0) ? base[7:0]
                                                                : 8'($urandom_range(0, 255));
                endcase
                send_item(OP_SYMBOL, sym);
            end
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input backs up
    task automatic test_backpressure();
        hold_cycles = 2000;
        no_idle = 1;
        test_random(6);
        no_idle = 0;
    endtask

    task automatic test_no_idle();
        no_idle = 1;
        test_random(40);
        no_idle = 0;
    endtask

    task automatic test_drain_pause();
        test_random(20);
        wait_drained();
        test_random(20);
    endtask

    initial begin
        model_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(700);
        test_no_idle();
        test_drain_pause();
        test_random(640);
        wait_drained();
        repeat (1000) @(posedge i_clk);
        if (errors == 0 && exp_wr == exp_rd) begin
            $display("adaptive_arithmetic_encoder_top regression: pass");
        end else begin
            $display("adaptive_arithmetic_encoder_top regression: fail");
        end
        $finish;
    end

endmodule
